/* rtl/core/skt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared widths, operation and status codes, the stored record layout and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int DEF_CAPACITY = 128;

	localparam int OP_W    = 2;
	localparam int KEY_W   = 32;
	localparam int AGE_W   = 7;
	localparam int GRADE_W = 4;
	localparam int IDX_W   = 7;
	localparam int ST_W    = 2;
	localparam int CNT_W   = 8;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [AGE_W-1:0]        age;
		logic [GRADE_W-1:0]      grade;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		RD_NONE,
		RD_FILL_M1,
		RD_PTR_M2,
		RD_ZERO,
		RD_PTR_P1,
		RD_PTR_P2,
		RD_IDX
	} rd_sel_t;

	typedef struct packed {
		logic            accept;
		logic            ld_ptr_fill;
		logic            ld_ptr_zero;
		logic            ptr_inc;
		logic            ptr_dec;
		rd_sel_t         rd_sel;
		logic            wr_rdata;
		logic            wr_new;
		logic            fill_inc;
		logic            fill_dec;
		logic            set_st;
		logic [ST_W-1:0] st;
		logic            cap_rd;
		logic            load_out;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            idx_ok;
		logic            key_gt;
		logic            key_eq;
		logic            ptr_is_one;
		logic            p1_lt_fill;
		logic            p2_lt_fill;
		logic            out_free;
	} stat_t;

endpackage

/* rtl/core/skt_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted key table controller
// Sequences insert, remove and read operations over the datapath.
// ----------------------------------------------------------------------------
module skt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  skt_pkg::stat_t stat,
	output skt_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DISP     = 8'b0000_0010,
		S_INS_CMP  = 8'b0000_0100,
		S_INS_PUT  = 8'b0000_1000,
		S_RM_SRCH  = 8'b0001_0000,
		S_RM_SHIFT = 8'b0010_0000,
		S_RD_WAIT  = 8'b0100_0000,
		S_FIN      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel = skt_pkg::RD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.op == skt_pkg::OP_INSERT) begin
					if (stat.full) begin
						cmd.set_st = 1'b1;
						cmd.st     = skt_pkg::ST_FULL;
						state_d    = S_FIN;
					end else if (stat.empty) begin
						cmd.ld_ptr_fill = 1'b1;
						state_d         = S_INS_PUT;
					end else begin
						cmd.ld_ptr_fill = 1'b1;
						cmd.rd_sel      = skt_pkg::RD_FILL_M1;
						state_d         = S_INS_CMP;
					end
				end else if (stat.op == skt_pkg::OP_REMOVE) begin
					if (stat.empty) begin
						cmd.set_st = 1'b1;
						cmd.st     = skt_pkg::ST_NOT_FOUND;
						state_d    = S_FIN;
					end else begin
						cmd.ld_ptr_zero = 1'b1;
						cmd.rd_sel      = skt_pkg::RD_ZERO;
						state_d         = S_RM_SRCH;
					end
				end else if (stat.op == skt_pkg::OP_READ) begin
					if (stat.idx_ok) begin
						cmd.rd_sel = skt_pkg::RD_IDX;
						state_d    = S_RD_WAIT;
					end else begin
						cmd.set_st = 1'b1;
						cmd.st     = skt_pkg::ST_RANGE;
						state_d    = S_FIN;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_INS_CMP: begin
				if (stat.key_gt) begin
					cmd.wr_rdata = 1'b1;
					cmd.ptr_dec  = 1'b1;
					if (stat.ptr_is_one) begin
						state_d = S_INS_PUT;
					end else begin
						cmd.rd_sel = skt_pkg::RD_PTR_M2;
					end
				end else begin
					cmd.wr_new   = 1'b1;
					cmd.fill_inc = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_INS_PUT: begin
				cmd.wr_new   = 1'b1;
				cmd.fill_inc = 1'b1;
				state_d      = S_FIN;
			end
			S_RM_SRCH: begin
				if (stat.key_eq) begin
					if (stat.p1_lt_fill) begin
						cmd.rd_sel = skt_pkg::RD_PTR_P1;
						state_d    = S_RM_SHIFT;
					end else begin
						cmd.fill_dec = 1'b1;
						state_d      = S_FIN;
					end
				end else if (stat.p1_lt_fill) begin
					cmd.rd_sel  = skt_pkg::RD_PTR_P1;
					cmd.ptr_inc = 1'b1;
				end else begin
					cmd.set_st = 1'b1;
					cmd.st     = skt_pkg::ST_NOT_FOUND;
					state_d    = S_FIN;
				end
			end
			S_RM_SHIFT: begin
				cmd.wr_rdata = 1'b1;
				cmd.ptr_inc  = 1'b1;
				if (stat.p2_lt_fill) begin
					cmd.rd_sel = skt_pkg::RD_PTR_P2;
				end else begin
					cmd.fill_dec = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_RD_WAIT: begin
				cmd.cap_rd = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/skt_datapath.sv */
// ----------------------------------------------------------------------------
// Sorted key table datapath
// Holds the operand word, the fill count, the walking pointer, the record
// memory and the result register.
// ----------------------------------------------------------------------------
module skt_datapath #(
	parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  skt_pkg::cmd_t                      cmd,
	output skt_pkg::stat_t                     stat,
	input  logic [skt_pkg::OP_W-1:0]           opcode,
	input  logic signed [skt_pkg::KEY_W-1:0]   key,
	input  logic [skt_pkg::AGE_W-1:0]          age,
	input  logic [skt_pkg::GRADE_W-1:0]        grade,
	input  logic [skt_pkg::IDX_W-1:0]          index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [skt_pkg::ST_W-1:0]           status,
	output logic [skt_pkg::CNT_W-1:0]          count,
	output logic signed [skt_pkg::KEY_W-1:0]   out_key,
	output logic [skt_pkg::AGE_W-1:0]          out_age,
	output logic [skt_pkg::GRADE_W-1:0]        out_grade
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = (FW > skt_pkg::IDX_W) ? FW : skt_pkg::IDX_W;
	localparam int EW = (FW > skt_pkg::CNT_W) ? FW : skt_pkg::CNT_W;

	logic [skt_pkg::OP_W-1:0]    op_q;
	skt_pkg::rec_t               new_q;
	logic [skt_pkg::IDX_W-1:0]   idx_q;
	logic [FW-1:0]               fill_q;
	logic [FW-1:0]               ptr_q;
	logic [skt_pkg::ST_W-1:0]    st_q;
	skt_pkg::rec_t               hold_q;

	skt_pkg::rec_t               rdata;
	skt_pkg::rec_t               wdata;
	logic [skt_pkg::REC_W-1:0]   rdata_raw;
	logic                        re;
	logic [AW-1:0]               raddr;
	logic [FW-1:0]               raddr_w;
	logic [CW-1:0]               idx_ext;
	logic [CW-1:0]               fill_ext;
	logic [FW:0]                 ptr_p1;
	logic [FW:0]                 ptr_p2;
	logic [EW-1:0]               fill_cnt;

	assign rdata   = skt_pkg::rec_t'(rdata_raw);
	assign idx_ext = CW'(idx_q);
	assign fill_ext = CW'(fill_q);
	assign ptr_p1  = (FW+1)'(ptr_q) + (FW+1)'(1);
	assign ptr_p2  = (FW+1)'(ptr_q) + (FW+1)'(2);
	assign fill_cnt = EW'(fill_q);

	assign stat.op         = op_q;
	assign stat.full       = (fill_q == FW'(CAPACITY));
	assign stat.empty      = (fill_q == '0);
	assign stat.idx_ok     = (idx_ext < fill_ext) && (idx_ext < CW'(CAPACITY));
	assign stat.key_gt     = (rdata.key > new_q.key);
	assign stat.key_eq     = (rdata.key == new_q.key);
	assign stat.ptr_is_one = (ptr_q == FW'(1));
	assign stat.p1_lt_fill = (ptr_p1 < (FW+1)'(fill_q));
	assign stat.p2_lt_fill = (ptr_p2 < (FW+1)'(fill_q));
	assign stat.out_free   = !out_valid || out_ready;

	always_comb begin
		re      = 1'b1;
		raddr_w = '0;
		unique case (cmd.rd_sel)
			skt_pkg::RD_NONE:    re      = 1'b0;
			skt_pkg::RD_FILL_M1: raddr_w = fill_q - FW'(1);
			skt_pkg::RD_PTR_M2:  raddr_w = ptr_q - FW'(2);
			skt_pkg::RD_ZERO:    raddr_w = '0;
			skt_pkg::RD_PTR_P1:  raddr_w = ptr_p1[FW-1:0];
			skt_pkg::RD_PTR_P2:  raddr_w = ptr_p2[FW-1:0];
			skt_pkg::RD_IDX:     raddr_w = FW'(idx_ext[AW-1:0]);
			default:             re      = 1'b0;
		endcase
		raddr = raddr_w[AW-1:0];
	end

	assign wdata = cmd.wr_new ? new_q : rdata;

	skt_ram #(
		.WIDTH (skt_pkg::REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_new || cmd.wr_rdata),
		.waddr (ptr_q[AW-1:0]),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q        <= opcode;
			new_q.key   <= key;
			new_q.age   <= age;
			new_q.grade <= grade;
			idx_q       <= index;
		end
		if (cmd.accept) begin
			st_q <= skt_pkg::ST_OK;
		end else if (cmd.set_st) begin
			st_q <= cmd.st;
		end
		if (cmd.accept) begin
			hold_q <= '0;
		end else if (cmd.cap_rd) begin
			hold_q <= rdata;
		end
		if (cmd.ld_ptr_fill) begin
			ptr_q <= fill_q;
		end else if (cmd.ld_ptr_zero) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + FW'(1);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - FW'(1);
		end
		if (cmd.load_out) begin
			status    <= st_q;
			count     <= fill_cnt[skt_pkg::CNT_W-1:0];
			out_key   <= hold_q.key;
			out_age   <= hold_q.age;
			out_grade <= hold_q.grade;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.fill_inc) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.fill_dec) begin
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/sorted_key_table_top.sv */
// ----------------------------------------------------------------------------
// Sorted key table
// Keeps up to CAPACITY records in ascending key order with a live count.
// ----------------------------------------------------------------------------
// Usage: an input word (opcode, key, age, grade, index) is taken on the input
// channel when in_valid and in_ready are both high. Each input word gives
// exactly one result word (status, count, out_key, out_age, out_grade) on the
// output channel, taken when out_valid and out_ready are both high.
// Insert walks down from the top of the table moving larger keys up one slot,
// one slot per cycle, and places the new record after equal keys. Remove scans
// from the bottom one slot per cycle and then closes the gap one slot per
// cycle. Both use the single read and single write port of the record memory.
// A word is refused at dispatch for an insert on a full table, a remove on an
// empty table, a read out of range or an unused opcode. A read waits for the
// registered read data before it is captured; an insert walks and a remove
// scans and shifts as above. The next word is accepted at the earliest in the
// cycle after the result is loaded into the output register.
// One word is in work at a time; in_ready is high only when the block is idle.
// A finished result waits in the output register, and the next word is
// accepted meanwhile; the block stalls at the end of that word only if the
// earlier result has still not been taken.
// Reset empties the table and clears the output channel; the memory itself
// is not cleared, since only written slots are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
	parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [skt_pkg::OP_W-1:0]         opcode,
	input  logic signed [skt_pkg::KEY_W-1:0] key,
	input  logic [skt_pkg::AGE_W-1:0]        age,
	input  logic [skt_pkg::GRADE_W-1:0]      grade,
	input  logic [skt_pkg::IDX_W-1:0]        index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [skt_pkg::ST_W-1:0]         status,
	output logic [skt_pkg::CNT_W-1:0]        count,
	output logic signed [skt_pkg::KEY_W-1:0] out_key,
	output logic [skt_pkg::AGE_W-1:0]        out_age,
	output logic [skt_pkg::GRADE_W-1:0]      out_grade
);

	skt_pkg::cmd_t  cmd;
	skt_pkg::stat_t stat;

	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	skt_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.key       (key),
		.age       (age),
		.grade     (grade),
		.index     (index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.count     (count),
		.out_key   (out_key),
		.out_age   (out_age),
		.out_grade (out_grade)
	);

endmodule
